[design/nlcs_pkg.sv]
// Shared types and constants for the nearest left cone steering block.
// No dependencies; imported by every module of the block.
package nlcs_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int OFFSET_WIDTH = 13;
   localparam int STEER_WIDTH  = 14;
   localparam int SQ_WIDTH     = 2 * COORD_WIDTH;

   // magnitudes are shrunk below 2^MAG_WIDTH before the offset math
   localparam int MAG_WIDTH    = 16;
   localparam longint SHRINK_LIMIT = 64'd1 << MAG_WIDTH;

   localparam int Q_WIDTH      = OFFSET_WIDTH;
   localparam int BIT_WIDTH    = $clog2(Q_WIDTH);
   localparam int T_WIDTH      = Q_WIDTH + 1;
   localparam int TT_WIDTH     = 2 * T_WIDTH;
   localparam int S_WIDTH      = 2 * MAG_WIDTH + 1;
   localparam int DM_WIDTH     = OFFSET_WIDTH + MAG_WIDTH;
   localparam int RHS_WIDTH    = 2 * DM_WIDTH + 2;
   localparam int PROD_WIDTH   = TT_WIDTH + S_WIDTH;
   localparam int WAY_WIDTH    = COORD_WIDTH + 2;

   localparam int CORDIC_ITERS = 16;
   localparam int ITER_WIDTH   = $clog2(CORDIC_ITERS);
   localparam int CORDIC_SHIFT = 16;
   localparam int CORDIC_WIDTH = COORD_WIDTH + CORDIC_SHIFT + 3;
   localparam int ANGLE_WIDTH  = 24;
   localparam int V_WIDTH      = 25;

   // angles in 1/25600 degree
   localparam int STEER_CENTER = 9000 * 256;
   localparam int STEER_MIN    = 6750 * 256;
   localparam int STEER_MAX    = 11250 * 256;
   localparam int STEER_ROUND  = 128;

   localparam logic [STEER_WIDTH-1:0] STEER_STRAIGHT = STEER_WIDTH'(9000);
   localparam logic [STEER_WIDTH-1:0] STEER_LEFT     = STEER_WIDTH'(6750);
   localparam logic [STEER_WIDTH-1:0] STEER_RIGHT    = STEER_WIDTH'(11250);

   localparam logic [OFFSET_WIDTH-1:0] OFFSET_RESET = OFFSET_WIDTH'(179);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] center_x;
      logic signed [COORD_WIDTH-1:0] center_y;
      logic                          frame_last;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] waypoint_x;
      logic signed [COORD_WIDTH-1:0] waypoint_y;
      logic [STEER_WIDTH-1:0]        steer_angle;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic                          left;
      logic                          last;
   } qitem_type;

   function automatic logic signed [ANGLE_WIDTH-1:0] atan_step(
      input logic [ITER_WIDTH-1:0] i);
      logic signed [ANGLE_WIDTH-1:0] r;
      begin
         case (i)
            4'd0:    r = 24'sd1152000;
            4'd1:    r = 24'sd680065;
            4'd2:    r = 24'sd359328;
            4'd3:    r = 24'sd182400;
            4'd4:    r = 24'sd91554;
            4'd5:    r = 24'sd45822;
            4'd6:    r = 24'sd22916;
            4'd7:    r = 24'sd11459;
            4'd8:    r = 24'sd5730;
            4'd9:    r = 24'sd2865;
            4'd10:   r = 24'sd1432;
            4'd11:   r = 24'sd716;
            4'd12:   r = 24'sd358;
            4'd13:   r = 24'sd179;
            4'd14:   r = 24'sd90;
            default: r = 24'sd45;
         endcase
         return r;
      end
   endfunction

   function automatic logic [COORD_WIDTH-1:0] mag_of(
      input logic signed [COORD_WIDTH-1:0] v);
      return v[COORD_WIDTH-1] ? COORD_WIDTH'(-v) : COORD_WIDTH'(v);
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] sat_of(
      input logic signed [WAY_WIDTH-1:0] v);
      logic signed [WAY_WIDTH-1:0] hi;
      logic signed [WAY_WIDTH-1:0] lo;
      begin
         hi = WAY_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
         lo = -hi - WAY_WIDTH'(1);
         if (v > hi)      return hi[COORD_WIDTH-1:0];
         else if (v < lo) return lo[COORD_WIDTH-1:0];
         else             return v[COORD_WIDTH-1:0];
      end
   endfunction

endpackage

[design/nearest_left_cone_steering_top.sv]
// Top level of the nearest left cone steering block.
// Depends on nlcs_pkg, nlcs_front and nlcs_back.
// Each frame streams in as cone centre words, frame_last on the final one. Centres
// are queued by the front end and consumed by the back end one at a time (square,
// then compare against the running minimum). On the frame's last centre, if a cone
// with y >= 0 was seen, one result word follows: the offset magnitudes come from a
// bit-serial search over 13 bits for each axis, then, for a waypoint with positive
// x, a 16-step CORDIC gives the angle. Frames with no left cone produce no word.
// The queue keeps accepting up to QUEUE_DEPTH centres while the back end works and
// while a result waits on rsp_stall.
module nearest_left_cone_steering_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  nlcs_pkg::req_type                 req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output nlcs_pkg::rsp_type                 rsp_word,
   input  logic                              csr_wr_en,
   input  logic [nlcs_pkg::OFFSET_WIDTH-1:0] csr_wr_data
);
   import nlcs_pkg::*;

   logic      head_valid;
   logic      head_pop;
   qitem_type head_item;

   nlcs_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop)
   );

   nlcs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_item   (head_item),
      .head_pop    (head_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

endmodule

[design/nlcs_front.sv]
// Front end: accepts centre words, tags left-side centres, queues them.
// Depends on nlcs_pkg.
module nlcs_front #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  nlcs_pkg::req_type  req_word,
   output logic               head_valid,
   output nlcs_pkg::qitem_type head_item,
   input  logic               head_pop
);
   import nlcs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   qitem_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push;
   logic             pop;
   qitem_type        item_in;

   assign req_stall  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign push       = req_valid && !req_stall;
   assign pop        = head_pop && head_valid;

   always_comb begin
      item_in.x    = req_word.center_x;
      item_in.y    = req_word.center_y;
      item_in.left = !req_word.center_y[COORD_WIDTH-1];
      item_in.last = req_word.frame_last;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("pop from empty queue");
`endif

endmodule

[design/nlcs_back.sv]
// Back end: running nearest-left minimum, offset search and CORDIC angle.
// Depends on nlcs_pkg; fed by nlcs_front's queue.
module nlcs_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  nlcs_pkg::qitem_type                 head_item,
   output logic                                head_pop,
   input  logic                                csr_wr_en,
   input  logic [nlcs_pkg::OFFSET_WIDTH-1:0]   csr_wr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output nlcs_pkg::rsp_type                   rsp_word
);
   import nlcs_pkg::*;

   typedef enum logic [3:0] {
      ST_POP, ST_CMP, ST_SHRINK, ST_SQ, ST_SUM, ST_RHS, ST_CAND, ST_TEST,
      ST_WAY, ST_CORDIC, ST_ANGLE, ST_OUT
   } state_type;

   state_type                      state_ff;
   logic [OFFSET_WIDTH-1:0]        offset_ff;
   qitem_type                      cur_ff;
   logic [SQ_WIDTH-1:0]            sqx_ff;
   logic [SQ_WIDTH-1:0]            sqy_ff;
   logic signed [COORD_WIDTH-1:0]  best_x_ff;
   logic signed [COORD_WIDTH-1:0]  best_y_ff;
   logic [SQ_WIDTH-1:0]            best_dsq_ff;
   logic                           found_ff;
   logic [COORD_WIDTH-1:0]         a_ff;
   logic [COORD_WIDTH-1:0]         b_ff;
   logic [2*MAG_WIDTH-1:0]         sqa_ff;
   logic [2*MAG_WIDTH-1:0]         sqb_ff;
   logic [S_WIDTH-1:0]             s_ff;
   logic [DM_WIDTH-1:0]            dm_ff;
   logic [RHS_WIDTH-1:0]           rhs_ff;
   logic                           pass_ff;
   logic [Q_WIDTH-1:0]             q_ff;
   logic [Q_WIDTH-1:0]             cand_ff;
   logic [BIT_WIDTH-1:0]           bit_ff;
   logic [TT_WIDTH-1:0]            tt_ff;
   logic [Q_WIDTH-1:0]             qx_ff;
   logic [Q_WIDTH-1:0]             qy_ff;
   logic signed [COORD_WIDTH-1:0]  wx_ff;
   logic signed [COORD_WIDTH-1:0]  wy_ff;
   logic signed [CORDIC_WIDTH-1:0] cx_ff;
   logic signed [CORDIC_WIDTH-1:0] cy_ff;
   logic signed [ANGLE_WIDTH-1:0]  z_ff;
   logic [ITER_WIDTH-1:0]          iter_ff;
   logic [STEER_WIDTH-1:0]         steer_ff;
   logic                           rsp_valid_ff;
   rsp_type                        rsp_ff;

   logic [SQ_WIDTH-1:0]            dsq;
   logic                           take;
   logic signed [COORD_WIDTH-1:0]  best_x_in;
   logic signed [COORD_WIDTH-1:0]  best_y_in;
   logic                           found_in;
   logic                           a_big;
   logic                           b_big;
   logic [MAG_WIDTH-1:0]           a16;
   logic [MAG_WIDTH-1:0]           b16;
   logic [Q_WIDTH-1:0]             cand;
   logic [T_WIDTH-1:0]             t;
   logic [PROD_WIDTH-1:0]          prod;
   logic [Q_WIDTH-1:0]             q_in;
   logic signed [WAY_WIDTH-1:0]    wx_full;
   logic signed [WAY_WIDTH-1:0]    wy_full;
   logic signed [COORD_WIDTH-1:0]  wx_in;
   logic signed [COORD_WIDTH-1:0]  wy_in;
   logic signed [CORDIC_WIDTH-1:0] dx;
   logic signed [CORDIC_WIDTH-1:0] dy;
   logic signed [V_WIDTH-1:0]      v;
   logic signed [V_WIDTH-1:0]      v_clamped;
   logic signed [V_WIDTH-1:0]      v_round;

   assign head_pop  = (state_ff == ST_POP) && head_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      dsq       = sqx_ff + sqy_ff;
      take      = cur_ff.left && (dsq < best_dsq_ff);
      best_x_in = take ? cur_ff.x : best_x_ff;
      best_y_in = take ? cur_ff.y : best_y_ff;
      found_in  = found_ff || take;

      a_big = (64'(a_ff) >= SHRINK_LIMIT);
      b_big = (64'(b_ff) >= SHRINK_LIMIT);
      a16   = a_ff[MAG_WIDTH-1:0];
      b16   = b_ff[MAG_WIDTH-1:0];

      cand = q_ff | (Q_WIDTH'(1) << bit_ff);
      t    = {cand, 1'b0} - T_WIDTH'(1);
      prod = PROD_WIDTH'(tt_ff) * PROD_WIDTH'(s_ff[S_WIDTH-2:0]);
      if (s_ff[S_WIDTH-1]) begin
         prod = prod + (PROD_WIDTH'(tt_ff) << (S_WIDTH - 1));
      end
      q_in = ((cand_ff <= offset_ff) && (prod <= PROD_WIDTH'(rhs_ff))) ? cand_ff : q_ff;

      wx_full = WAY_WIDTH'(best_x_ff);
      wy_full = WAY_WIDTH'(best_y_ff);
      if (s_ff != '0) begin
         if (best_y_ff > 0) begin
            wx_full = wx_full - $signed({2'b00, qx_ff});
         end else if (best_y_ff < 0) begin
            wx_full = wx_full + $signed({2'b00, qx_ff});
         end
         if (best_x_ff > 0) begin
            wy_full = wy_full + $signed({2'b00, qy_ff});
         end else if (best_x_ff < 0) begin
            wy_full = wy_full - $signed({2'b00, qy_ff});
         end
      end
      wx_in = sat_of(wx_full);
      wy_in = sat_of(wy_full);

      dx = cy_ff >>> iter_ff;
      dy = cx_ff >>> iter_ff;

      v = V_WIDTH'(STEER_CENTER) - V_WIDTH'(z_ff);
      if (v < V_WIDTH'(STEER_MIN)) begin
         v_clamped = V_WIDTH'(STEER_MIN);
      end else if (v > V_WIDTH'(STEER_MAX)) begin
         v_clamped = V_WIDTH'(STEER_MAX);
      end else begin
         v_clamped = v;
      end
      v_round = (v_clamped + V_WIDTH'(STEER_ROUND)) >>> 8;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_POP;
         offset_ff    <= OFFSET_RESET;
         best_x_ff    <= '0;
         best_y_ff    <= '0;
         best_dsq_ff  <= '1;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            offset_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_POP: begin
               if (head_valid) begin
                  cur_ff   <= head_item;
                  sqx_ff   <= SQ_WIDTH'(head_item.x * head_item.x);
                  sqy_ff   <= SQ_WIDTH'(head_item.y * head_item.y);
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               if (cur_ff.last && found_in) begin
                  best_x_ff   <= best_x_in;
                  best_y_ff   <= best_y_in;
                  best_dsq_ff <= take ? dsq : best_dsq_ff;
                  found_ff    <= found_in;
                  a_ff        <= mag_of(best_x_in);
                  b_ff        <= mag_of(best_y_in);
                  state_ff    <= ST_SHRINK;
               end else if (cur_ff.last) begin
                  best_x_ff   <= '0;
                  best_y_ff   <= '0;
                  best_dsq_ff <= '1;
                  found_ff    <= 1'b0;
                  state_ff    <= ST_POP;
               end else begin
                  best_x_ff   <= best_x_in;
                  best_y_ff   <= best_y_in;
                  best_dsq_ff <= take ? dsq : best_dsq_ff;
                  found_ff    <= found_in;
                  state_ff    <= ST_POP;
               end
            end
            ST_SHRINK: begin
               if (a_big || b_big) begin
                  a_ff <= a_ff >> 1;
                  b_ff <= b_ff >> 1;
               end else begin
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               sqa_ff   <= a16 * a16;
               sqb_ff   <= b16 * b16;
               pass_ff  <= 1'b0;
               qx_ff    <= '0;
               qy_ff    <= '0;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               s_ff     <= S_WIDTH'(sqa_ff) + S_WIDTH'(sqb_ff);
               dm_ff    <= DM_WIDTH'(offset_ff) * DM_WIDTH'(pass_ff ? a16 : b16);
               state_ff <= ST_RHS;
            end
            ST_RHS: begin
               rhs_ff   <= (RHS_WIDTH'(dm_ff) * RHS_WIDTH'(dm_ff)) << 2;
               q_ff     <= '0;
               bit_ff   <= BIT_WIDTH'(Q_WIDTH - 1);
               state_ff <= (s_ff == '0) ? ST_WAY : ST_CAND;
            end
            ST_CAND: begin
               cand_ff  <= cand;
               tt_ff    <= TT_WIDTH'(t) * TT_WIDTH'(t);
               state_ff <= ST_TEST;
            end
            ST_TEST: begin
               q_ff <= q_in;
               if (bit_ff == '0) begin
                  if (!pass_ff) begin
                     qx_ff    <= q_in;
                     pass_ff  <= 1'b1;
                     state_ff <= ST_SUM;
                  end else begin
                     qy_ff    <= q_in;
                     state_ff <= ST_WAY;
                  end
               end else begin
                  bit_ff   <= bit_ff - 1'b1;
                  state_ff <= ST_CAND;
               end
            end
            ST_WAY: begin
               wx_ff   <= wx_in;
               wy_ff   <= wy_in;
               cx_ff   <= CORDIC_WIDTH'(wx_in) <<< CORDIC_SHIFT;
               cy_ff   <= CORDIC_WIDTH'(wy_in) <<< CORDIC_SHIFT;
               z_ff    <= '0;
               iter_ff <= '0;
               if (wx_in == '0 && wy_in == '0) begin
                  steer_ff <= STEER_STRAIGHT;
                  state_ff <= ST_OUT;
               end else if (wx_in <= 0) begin
                  steer_ff <= wy_in[COORD_WIDTH-1] ? STEER_RIGHT : STEER_LEFT;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_CORDIC;
               end
            end
            ST_CORDIC: begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + dx;
                  cy_ff <= cy_ff - dy;
                  z_ff  <= z_ff + atan_step(iter_ff);
               end else begin
                  cx_ff <= cx_ff - dx;
                  cy_ff <= cy_ff + dy;
                  z_ff  <= z_ff - atan_step(iter_ff);
               end
               iter_ff <= iter_ff + 1'b1;
               if (iter_ff == ITER_WIDTH'(CORDIC_ITERS - 1)) begin
                  state_ff <= ST_ANGLE;
               end
            end
            ST_ANGLE: begin
               steer_ff <= v_round[STEER_WIDTH-1:0];
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.waypoint_x  <= wx_ff;
                  rsp_ff.waypoint_y  <= wy_ff;
                  rsp_ff.steer_angle <= steer_ff;
                  best_x_ff          <= '0;
                  best_y_ff          <= '0;
                  best_dsq_ff        <= '1;
                  found_ff           <= 1'b0;
                  state_ff           <= ST_POP;
               end
            end
            default: state_ff <= ST_POP;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_empty_best: assert property (@(posedge clock) disable iff (reset)
      !found_ff |-> (best_dsq_ff == '1))
      else $error("best distance set without a left cone");
   a_steer_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.steer_angle >= STEER_LEFT && rsp_ff.steer_angle <= STEER_RIGHT))
      else $error("steering angle out of range");
   a_shrunk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ) |-> (!a_big && !b_big))
      else $error("magnitudes not shrunk before squaring");
`endif

endmodule
